// ===== design/binco_pkg.sv =====
`default_nettype none
package binco_pkg;
  localparam int unsigned NMax = 60;
  localparam int unsigned ArgW = 6;
  localparam int unsigned CoefW = 57;
  localparam int unsigned AccW = 64;
  localparam int unsigned DivW = 6;
  localparam int unsigned CellN = 4;
  localparam int unsigned BitsPerCell = AccW / CellN;

  typedef struct packed {
    logic [ArgW-1:0] n_value;
    logic [ArgW-1:0] k_value;
  } in_word_t;

  typedef struct packed {
    logic [CoefW-1:0] coefficient;
    logic             range_error;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/binco_if.sv =====
`default_nettype none
interface binco_in_if (input wire logic clk_i);
  logic               valid;
  logic               ready;
  binco_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface binco_out_if (input wire logic clk_i);
  logic                 valid;
  logic                 ready;
  binco_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/binco_cell.sv =====
`default_nettype none
// one slice of the dividend/quotient shift register: takes the bit from the
// lower neighbor at its lsb and hands its msb to the upper neighbor
module binco_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire binco_pkg::cell_ctl_t              ctl_i,
  input  wire logic [binco_pkg::BitsPerCell-1:0] load_i,
  input  wire logic                              bit_i,
  output logic                                   bit_o,
  output logic [binco_pkg::BitsPerCell-1:0]      slice_o
);
  localparam int unsigned W = binco_pkg::BitsPerCell;

  logic [W-1:0] slice_q, slice_d;

  always_comb begin
    slice_d = slice_q;
    if (ctl_i.start) begin
      slice_d = load_i;
    end else if (ctl_i.shift) begin
      slice_d = {slice_q[W-2:0], bit_i};
    end
  end

  assign bit_o   = slice_q[W-1];
  assign slice_o = slice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '0;
    end else begin
      slice_q <= slice_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/binomial_coefficient_core.sv =====
`default_nettype none
// k' = min(k, n-k) <= 30 is the number of multiply-divide rounds run for a word; the result follows
// in the next cycle when k' is zero, when k exceeds n or when an argument is out of range
// one word at a time: the next is taken at the earliest in the cycle after the result is handed off
// each round: a multiply step, a load step, a shift of every accumulator bit through a chain of four
// 16-bit cells with a restoring step at the top, and a capture of the quotient
// reset: asynchronous active low, returns to idle with no result pending
module binomial_coefficient_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  binco_in_if.sink   in_i,
  binco_out_if.source out_o
);
  localparam int unsigned A = binco_pkg::AccW;
  localparam int unsigned W = binco_pkg::BitsPerCell;
  localparam int unsigned C = binco_pkg::CellN;
  localparam int unsigned D = binco_pkg::DivW;
  localparam int unsigned CntW = $clog2(A + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SLoad = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [A-1:0] acc_q, acc_d;
  logic [D-1:0] n_q, n_d, k_q, k_d, i_q, i_d;
  logic [D-1:0] rem_q, rem_d, rem_step;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic rerr_q, rerr_d;
  binco_pkg::cell_ctl_t ctl;
  logic [C:0] link;
  logic [W-1:0] quo [C];
  logic [A-1:0] quot;
  logic [D:0] r_trial;
  logic qbit;
  logic [D-1:0] nn, kk, kr;
  logic [A-1:0] prod;

  assign nn = in_i.data.n_value;
  assign kk = in_i.data.k_value;
  assign kr = (({1'b0, kk} << 1) > {1'b0, nn}) ? nn - kk : kk;
  assign prod = acc_q * {{(A-D){1'b0}}, (n_q - k_q + i_q)};

  // restoring step on the msb leaving the top cell
  assign r_trial = {rem_q, link[0]};
  assign qbit = (r_trial >= {1'b0, i_q});
  always_comb begin
    if (qbit) begin
      rem_step = D'(r_trial - {1'b0, i_q});
    end else begin
      rem_step = r_trial[D-1:0];
    end
  end
  assign link[C] = qbit;

  // cell 0 holds the top slice, bits move up one place per shift
  genvar g;
  generate
    for (g = 0; g < C; g++) begin : g_cell
      binco_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl),
        .load_i  (acc_q[A-1-g*W -: W]),
        .bit_i   (link[g+1]),
        .bit_o   (link[g]),
        .slice_o (quo[g])
      );
      assign quot[A-1-g*W -: W] = quo[g];
    end
  endgenerate

  always_comb begin
    st_d = st_q; acc_d = acc_q; n_d = n_q; k_d = k_q; i_d = i_q;
    cnt_d = cnt_q; rerr_d = rerr_q; rem_d = rem_q;
    ctl.start = 1'b0; ctl.shift = 1'b0;
    unique case (st_q)
      SIdle: if (in_i.valid) begin
        n_d = nn; k_d = kr; i_d = D'(1); acc_d = A'(1); rerr_d = 1'b0;
        if (nn > D'(binco_pkg::NMax) || kk > D'(binco_pkg::NMax)) begin
          rerr_d = 1'b1; acc_d = '0; st_d = SOut;
        end else if (kk > nn) begin
          acc_d = '0; st_d = SOut;
        end else if (kr == '0) begin
          st_d = SOut;
        end else begin
          st_d = SMul;
        end
      end
      SMul: begin acc_d = prod; st_d = SLoad; end
      SLoad: begin ctl.start = 1'b1; cnt_d = '0; rem_d = '0; st_d = SDiv; end
      SDiv: begin
        if (cnt_q == CntW'(A)) begin
          acc_d = quot;
          i_d = i_q + D'(1);
          st_d = (i_q == k_q) ? SOut : SMul;
        end else begin
          ctl.shift = 1'b1;
          rem_d = rem_step;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      SOut: if (out_o.ready) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign in_i.ready = (st_q == SIdle);
  assign out_o.valid = (st_q == SOut);
  assign out_o.data.coefficient = acc_q[binco_pkg::CoefW-1:0];
  assign out_o.data.range_error = rerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; n_q <= n_d; k_q <= k_d; i_q <= i_d; rerr_q <= rerr_d;
  end
endmodule
`default_nettype wire

// ===== design/binco_checker.sv =====
`default_nettype none
module binco_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [binco_pkg::CoefW-1:0] coef_i,
  input wire logic rerr_i
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("ready while result pending");
  a_rerr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && rerr_i) |-> coef_i == '0) else $error("range error with value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(coef_i))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("second word taken");
endmodule

bind binomial_coefficient_core binco_checker u_binco_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .coef_i      (out_o.data.coefficient),
  .rerr_i      (out_o.data.range_error)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  binco_in_if  in_ch (clk_i);
  binco_out_if out_ch (clk_i);

  binomial_coefficient_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  binco_pkg::in_word_t  pending_q[$];
  binco_pkg::out_word_t coef_q[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  bit hold_start = 1'b0;

  function automatic binco_pkg::out_word_t choose_word(binco_pkg::in_word_t w);
    binco_pkg::out_word_t r;
    logic [63:0] n;
    logic [63:0] k;
    logic [63:0] acc;
    r.coefficient = '0;
    r.range_error = 1'b0;
    n = 64'(w.n_value);
    k = 64'(w.k_value);
    if (n > binco_pkg::NMax || k > binco_pkg::NMax) begin
      r.range_error = 1'b1;
      return r;
    end
    if (k > n) return r;
    if (2 * k > n) k = n - k;
    acc = 64'd1;
    for (logic [63:0] i = 1; i <= k; i++) begin
      acc = (acc * (n - k + i)) / i;
    end
    r.coefficient = acc[binco_pkg::CoefW-1:0];
    return r;
  endfunction

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
  end

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      coef_q.push_back(choose_word(in_ch.data));
      void'(pending_q.pop_front());
    end
    if (pending_q.size() > 0 && (in_ch.valid && !in_ch.ready)) begin
      in_ch.valid <= 1'b1;
    end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.data <= pending_q[0];
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  initial out_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_ch.data);
      end else begin
        binco_pkg::out_word_t e;
        e = coef_q.pop_front();
        if (e.coefficient !== out_ch.data.coefficient ||
            e.range_error !== out_ch.data.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected coef %0d err %0b, got coef %0d err %0b",
                     e.coefficient, e.range_error, out_ch.data.coefficient,
                     out_ch.data.range_error);
        end
      end
    end
    out_ch.ready <= !hold_recv && rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold
  initial begin
    wait (hold_start);
    hold_recv = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_recv = 1'b0;
  end

  task automatic add_word(int n, int k);
    binco_pkg::in_word_t w;
    w.n_value = n[binco_pkg::ArgW-1:0];
    w.k_value = k[binco_pkg::ArgW-1:0];
    pending_q.push_back(w);
  endtask

  task automatic add_random(int count);
    for (int j = 0; j < count; j++) begin
      int r;
      r = $urandom_range(99);
      if (r < 8) add_word($urandom_range(63), $urandom_range(63));
      else if (r < 20) add_word($urandom_range(25), $urandom_range(60));
      else begin
        int n;
        n = (r < 35) ? $urandom_range(60, 50) : $urandom_range(30);
        add_word(n, $urandom_range(n));
      end
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || coef_q.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    add_word(0, 0);    add_word(60, 0);   add_word(60, 60);  add_word(60, 30);
    add_word(60, 29);  add_word(60, 31);  add_word(59, 30);  add_word(61, 0);
    add_word(0, 61);   add_word(63, 63);  add_word(63, 0);   add_word(0, 63);
    add_word(5, 6);    add_word(0, 60);   add_word(1, 1);    add_word(42, 21);
    add_word(21, 42);  add_word(60, 1);   add_word(60, 59);  add_word(31, 31);
    add_word(32, 16);  add_word(62, 30);  add_word(48, 24);
    drain();

    add_random(60);
    drain();
    send_idle_pct = 80;
    add_random(50);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 80;
    add_random(50);
    drain();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    add_random(50);
    // long receiver hold while the sender keeps offering
    hold_start = 1'b1;
    @(posedge clk_i);
    wait (!hold_recv);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(60);
    drain();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && coef_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
